@@ rtl/c3lbf_pkg.sv @@
// Shared constants, types and helpers of the 3x3 line-buffered filter.
package c3lbf_pkg;

    localparam int LINE_MAX   = 1024;
    localparam int KSIZE      = 3;
    localparam int PTR_W      = $clog2(LINE_MAX);
    localparam int CNT_W      = PTR_W + 1;
    localparam int LWIDTH_W   = 11;
    localparam int PIX_W      = 8;
    localparam int WEIGHT_W   = 16;
    localparam int ROW_W      = KSIZE * WEIGHT_W;
    localparam int PROD_W     = PIX_W + 1 + WEIGHT_W;
    localparam int ACC_W      = PROD_W + 4;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = ROW_W;

    localparam logic [ROW_W-1:0]    WEIGHTS_RESET    = 48'h0019_0019_0019;
    localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_W_TOP      = 8'd0,
        REG_W_MID      = 8'd1,
        REG_W_NOW      = 8'd2,
        REG_LINE_WIDTH = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] now;
        logic [PIX_W-1:0] one_up;
        logic [PIX_W-1:0] two_up;
    } column_t;

    // [row][col], row 0 = two lines up, col 0 = oldest
    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] window_t;
    typedef logic [KSIZE-1:0][ROW_W-1:0] weights_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    function automatic logic [CNT_W-1:0] eff_width(input logic [LWIDTH_W-1:0] w);
        logic [CNT_W-1:0] r;
        if (int'(w) > LINE_MAX) begin
            r = CNT_W'(LINE_MAX);
        end else if (w == '0) begin
            r = CNT_W'(1);
        end else begin
            r = CNT_W'(w);
        end
        return r;
    endfunction

endpackage

@@ rtl/c3lbf_line_buf.sv @@
// Two circular line stores with shared pointer; emits one pixel column per word.
module c3lbf_line_buf (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [c3lbf_pkg::LWIDTH_W-1:0]      line_width,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [c3lbf_pkg::PIX_W-1:0]         in_pixel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output c3lbf_pkg::column_t                  out_col
);
    import c3lbf_pkg::*;

    logic [PIX_W-1:0] store_one [LINE_MAX];
    logic [PIX_W-1:0] store_two [LINE_MAX];

    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] hwm_reg, hwm_next;
    logic [CNT_W-1:0] width_eff, ptr_inc;
    logic             v_reg;
    logic             wr2_reg;
    logic [PTR_W-1:0] addr_reg;
    logic [PIX_W-1:0] pixel_reg, one_reg, two_reg;
    logic             accept, rd_ok, fwd;

    assign in_ready  = !v_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign width_eff = eff_width(line_width);
    assign ptr_inc   = {1'b0, ptr_reg} + CNT_W'(1);
    assign ptr_next  = (ptr_inc >= width_eff) ? '0 : ptr_inc[PTR_W-1:0];
    assign hwm_next  = (ptr_inc > hwm_reg) ? ptr_inc : hwm_reg;
    // written entries always form a prefix, so hwm marks what is valid
    assign rd_ok     = {1'b0, ptr_reg} < hwm_reg;
    assign fwd       = wr2_reg && (addr_reg == ptr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            hwm_reg <= '0;
            wr2_reg <= 1'b0;
            v_reg   <= 1'b0;
        end else begin
            if (accept) begin
                ptr_reg <= ptr_next;
                hwm_reg <= hwm_next;
                wr2_reg <= 1'b1;
                v_reg   <= 1'b1;
            end else if (out_ready) begin
                v_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            one_reg            <= rd_ok ? store_one[ptr_reg] : '0;
            store_one[ptr_reg] <= in_pixel;
            pixel_reg          <= in_pixel;
            addr_reg           <= ptr_reg;
        end
    end

    // second store is written in the cycle after the first: it takes the word read from the first
    always_ff @(posedge aclk) begin
        if (wr2_reg) begin
            store_two[addr_reg] <= one_reg;
        end
        if (accept) begin
            two_reg <= fwd ? one_reg : (rd_ok ? store_two[ptr_reg] : '0);
        end
    end

    assign out_valid      = v_reg;
    assign out_col.now    = pixel_reg;
    assign out_col.one_up = one_reg;
    assign out_col.two_up = two_reg;

`ifndef SYNTH
    a_ptr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (ptr_reg == '0 || {1'b0, ptr_reg} == $past(ptr_inc)))
        else $error("line pointer did not advance or wrap");
    a_ptr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> ptr_reg == $past(ptr_reg))
        else $error("line pointer moved without a word");
    a_hwm_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (hwm_reg >= $past(hwm_reg) && {1'b0, ptr_reg} <= hwm_reg))
        else $error("fill mark shrank or pointer ran past it");
`endif

endmodule

@@ rtl/c3lbf_window.sv @@
// 3x3 window register, shifted by one column per word.
module c3lbf_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  c3lbf_pkg::column_t  in_col,
    output logic                out_valid,
    input  logic                out_ready,
    output c3lbf_pkg::window_t  out_win
);
    import c3lbf_pkg::*;

    window_t win_reg;
    logic    v_reg;
    logic    accept;

    assign in_ready = !v_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
            v_reg   <= 1'b0;
        end else begin
            if (accept) begin
                for (int r = 0; r < KSIZE; r++) begin
                    for (int c = 0; c < KSIZE - 1; c++) begin
                        win_reg[r][c] <= win_reg[r][c+1];
                    end
                end
                win_reg[0][KSIZE-1] <= in_col.two_up;
                win_reg[1][KSIZE-1] <= in_col.one_up;
                win_reg[2][KSIZE-1] <= in_col.now;
                v_reg <= 1'b1;
            end else if (out_ready) begin
                v_reg <= 1'b0;
            end
        end
    end

    assign out_valid = v_reg;
    assign out_win   = win_reg;

endmodule

@@ rtl/c3lbf_mac.sv @@
// Nine weight products, registered, then summed into the output register.
module c3lbf_mac (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  c3lbf_pkg::weights_t         weights,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  c3lbf_pkg::window_t          in_win,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [c3lbf_pkg::PIX_W-1:0] out_pixel
);
    import c3lbf_pkg::*;

    prod_t             prod_reg  [KSIZE][KSIZE];
    prod_t             prod_next [KSIZE][KSIZE];
    logic              vp_reg, vo_reg;
    logic              en_o, accept;
    logic signed [ACC_W-1:0] acc;
    logic [PIX_W-1:0]  out_reg;

    assign en_o     = !vo_reg || out_ready;
    assign in_ready = !vp_reg || en_o;
    assign accept   = in_valid && in_ready;

    always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE; c++) begin
                prod_next[r][c] = $signed({1'b0, in_win[r][c]})
                                * $signed(weights[r][c*WEIGHT_W +: WEIGHT_W]);
            end
        end
    end

    always_comb begin
        acc = '0;
        for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE; c++) begin
                acc = acc + ACC_W'(prod_reg[r][c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (accept) begin
                vp_reg <= 1'b1;
            end else if (en_o) begin
                vp_reg <= 1'b0;
            end
            if (en_o) begin
                vo_reg <= vp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prod_reg <= prod_next;
        end
        if (en_o && vp_reg) begin
            out_reg <= acc[FRAC_W +: PIX_W];
        end
    end

    assign out_valid = vo_reg;
    assign out_pixel = out_reg;

endmodule

@@ rtl/conv3x3_line_buffered_filter.sv @@
// 3x3 convolution over a raster pixel stream using two line stores.
//
// Input stream s_*: one 8-bit pixel per word in raster order.
// Output stream m_*: one 8-bit pixel per input word, the low 8 bits of the
//   integer part of the signed 21.8 weighted sum over the 3x3 window.
// Config channel cfg_*: index 0..2 load the three weight rows (top, middle,
//   current; three signed 8.8 lanes, oldest column in bits [15:0]), index 3
//   loads the line width. Other indexes are ignored. cfg_ready is always high.
//   Write only while the pipeline is empty.
// Throughput: one word per clock while m_tready is high; each store is read
//   once per word; the first is written once per word, the second every clock.
// Pipeline: an accepted word passes line store read, window shift, product
//   register and sum into output register before m_tvalid rises.
// Reset: weights return to 25/256 per tap, line width to 1024, window and
//   pointer clear; no clearing pass is needed, unwritten store entries read
//   as zero. s_tready is low while aresetn is low.
// Stall: each stage holds while the next is full, so with m_tready low the
//   block still accepts words until its four stages are full.
module conv3x3_line_buffered_filter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,    // [7:0] pixel_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,    // [7:0] pixel_out
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [c3lbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [c3lbf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import c3lbf_pkg::*;

    logic [ROW_W-1:0]    w_top_reg, w_mid_reg, w_now_reg;
    logic [LWIDTH_W-1:0] line_width_reg;
    weights_t            weights;

    logic    lb_ready, lb_valid, win_ready, win_valid, mac_ready;
    column_t col;
    window_t win;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_top_reg      <= WEIGHTS_RESET;
            w_mid_reg      <= WEIGHTS_RESET;
            w_now_reg      <= WEIGHTS_RESET;
            line_width_reg <= LINE_WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_W_TOP:      w_top_reg      <= cfg_data;
                REG_W_MID:      w_mid_reg      <= cfg_data;
                REG_W_NOW:      w_now_reg      <= cfg_data;
                REG_LINE_WIDTH: line_width_reg <= cfg_data[LWIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign weights[0] = w_top_reg;
    assign weights[1] = w_mid_reg;
    assign weights[2] = w_now_reg;

    assign s_tready = lb_ready && aresetn;

    c3lbf_line_buf u_line_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_width (line_width_reg),
        .in_valid   (s_tvalid && aresetn),
        .in_ready   (lb_ready),
        .in_pixel   (s_tdata[PIX_W-1:0]),
        .out_valid  (lb_valid),
        .out_ready  (win_ready),
        .out_col    (col)
    );

    c3lbf_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lb_valid),
        .in_ready  (win_ready),
        .in_col    (col),
        .out_valid (win_valid),
        .out_ready (mac_ready),
        .out_win   (win)
    );

    c3lbf_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .weights   (weights),
        .in_valid  (win_valid),
        .in_ready  (mac_ready),
        .in_win    (win),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata)
    );

endmodule
